// ===== rtl/deq_pkg.sv =====
// Shared types and codes for the double-ended queue.
package deq_pkg;

  localparam int ID_W = 16;

  // Command queue between the front and back parts.
  localparam int CMDQ_DEPTH = 2;
  localparam int CMDQ_AW    = 1;
  localparam int CMDQ_CW    = 2;

  typedef enum logic [2:0] {
    KIND_PUSH_FRONT = 3'd0,
    KIND_PUSH_REAR  = 3'd1,
    KIND_POP_FRONT  = 3'd2,
    KIND_POP_REAR   = 3'd3,
    KIND_LIST       = 3'd4
  } kind_t;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [2:0]      kind;
    logic [ID_W-1:0] order_id;
  } in_item_t;

  typedef struct packed {
    logic [1:0]      status;
    logic [ID_W-1:0] order_value;
    logic            last_of_run;
  } out_item_t;

  typedef struct packed {
    kind_t           kind;
    logic [ID_W-1:0] order_id;
  } cmd_t;

endpackage

// ===== rtl/deq_front.sv =====
// Front part: accepts commands, drops unused kinds and queues the rest.
module deq_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  deq_pkg::in_item_t in_data,
  output logic              cmd_valid,
  output deq_pkg::cmd_t     cmd,
  input  logic              cmd_take
);

  deq_pkg::cmd_t                 q_r [deq_pkg::CMDQ_DEPTH];
  logic [deq_pkg::CMDQ_AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [deq_pkg::CMDQ_AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [deq_pkg::CMDQ_CW-1:0]   cnt_r, cnt_nxt;
  logic                          known_kind;
  logic                          q_push;
  logic                          q_pop;

  assign in_ready   = (cnt_r != deq_pkg::CMDQ_CW'(deq_pkg::CMDQ_DEPTH));
  assign known_kind = (in_data.kind <= deq_pkg::KIND_LIST);
  // Unused kinds are taken and discarded without a result.
  assign q_push     = in_valid && in_ready && known_kind;
  assign cmd_valid  = (cnt_r != '0);
  assign q_pop      = cmd_take && cmd_valid;
  assign cmd        = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = q_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = q_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + deq_pkg::CMDQ_CW'(q_push) - deq_pkg::CMDQ_CW'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_push) begin
      q_r[wr_ptr_r] <= '{kind: deq_pkg::kind_t'(in_data.kind), order_id: in_data.order_id};
    end
  end

endmodule

// ===== rtl/deq_back.sv =====
// Back part: ring storage, head and count, and the result register.
module deq_back #(
  parameter int DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cmd_valid,
  input  deq_pkg::cmd_t      cmd,
  output logic               cmd_take,
  output logic               out_valid,
  input  logic               out_ready,
  output deq_pkg::out_item_t out_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EMIT = 2'b10
  } state_t;

  state_t                     state_r, state_nxt;
  logic [AW-1:0]              head_r, head_nxt;
  logic [CW-1:0]              count_r, count_nxt;
  logic [CW-1:0]              idx_r, idx_nxt;
  logic                       out_valid_r, out_valid_nxt;
  deq_pkg::out_item_t         out_data_r;
  logic [deq_pkg::ID_W-1:0]   mem [DEPTH];
  logic [deq_pkg::ID_W-1:0]   rd_data_r;

  logic                       can_load;
  logic                       load;
  deq_pkg::out_item_t         load_data;
  logic                       wr_en;
  logic [AW-1:0]              wr_addr;
  logic                       rd_en;
  logic [AW-1:0]              rd_addr;
  logic                       is_full;
  logic                       is_empty;
  logic [AW-1:0]              head_dec;
  logic [CW-1:0]              idx_inc;
  logic                       list_done;
  logic                       push_ok;

  function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] base,
                                             input logic [AW-1:0] off);
    logic [AW:0] s;
    s = {1'b0, base} + {1'b0, off};
    if (s >= (AW+1)'(DEPTH)) begin
      s = s - (AW+1)'(DEPTH);
    end
    return s[AW-1:0];
  endfunction

  assign can_load  = !out_valid_r || out_ready;
  assign is_full   = (count_r == CW'(DEPTH));
  assign is_empty  = (count_r == '0);
  assign head_dec  = (head_r == '0) ? AW'(DEPTH - 1) : head_r - 1'b1;
  assign idx_inc   = idx_r + 1'b1;
  assign list_done = (idx_inc == count_r);

  always_comb begin
    state_nxt = state_r;
    head_nxt  = head_r;
    count_nxt = count_r;
    idx_nxt   = idx_r;
    cmd_take  = 1'b0;
    load      = 1'b0;
    load_data = '{status: deq_pkg::ST_OK, order_value: '0, last_of_run: 1'b1};
    wr_en     = 1'b0;
    wr_addr   = head_r;
    rd_en     = 1'b0;
    rd_addr   = head_r;
    push_ok   = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (cmd_valid) begin
          unique case (cmd.kind)
            deq_pkg::KIND_PUSH_FRONT, deq_pkg::KIND_PUSH_REAR: begin
              if (can_load) begin
                cmd_take = 1'b1;
                load     = 1'b1;
                if (is_full) begin
                  load_data.status = deq_pkg::ST_FULL;
                end else begin
                  wr_en     = 1'b1;
                  push_ok   = 1'b1;
                  count_nxt = count_r + 1'b1;
                  if (cmd.kind == deq_pkg::KIND_PUSH_FRONT) begin
                    wr_addr  = head_dec;
                    head_nxt = head_dec;
                  end else begin
                    wr_addr = ring_add(head_r, count_r[AW-1:0]);
                  end
                end
              end
            end
            deq_pkg::KIND_POP_FRONT, deq_pkg::KIND_POP_REAR, deq_pkg::KIND_LIST: begin
              if (is_empty) begin
                if (can_load) begin
                  cmd_take         = 1'b1;
                  load             = 1'b1;
                  load_data.status = deq_pkg::ST_EMPTY;
                end
              end else begin
                // The first entry is read now and reported once it is registered.
                rd_en     = 1'b1;
                idx_nxt   = '0;
                state_nxt = S_EMIT;
                if (cmd.kind == deq_pkg::KIND_POP_REAR) begin
                  rd_addr = ring_add(head_r, AW'(count_r - 1'b1));
                end
              end
            end
            default: ;
          endcase
        end
      end
      S_EMIT: begin
        if (can_load) begin
          load                  = 1'b1;
          load_data.order_value = rd_data_r;
          if ((cmd.kind == deq_pkg::KIND_LIST) && !list_done) begin
            // Fetch the next entry while this one is handed over.
            load_data.last_of_run = 1'b0;
            rd_en                 = 1'b1;
            rd_addr               = ring_add(head_r, idx_inc[AW-1:0]);
            idx_nxt               = idx_inc;
          end else begin
            cmd_take  = 1'b1;
            state_nxt = S_IDLE;
            if (cmd.kind == deq_pkg::KIND_POP_FRONT) begin
              head_nxt  = ring_add(head_r, AW'(1));
              count_nxt = count_r - 1'b1;
            end else if (cmd.kind == deq_pkg::KIND_POP_REAR) begin
              count_nxt = count_r - 1'b1;
            end
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      count_r     <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data_r <= load_data;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= cmd.order_id;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("entry count above capacity");

  a_emit_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT) |-> (count_r != '0))
    else $error("reading entries of an empty ring");

  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    push_ok |=> (count_r == CW'($past(count_r) + 1'b1)))
    else $error("accepted push did not grow the ring");

  a_full_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (load && (load_data.status == deq_pkg::ST_FULL)) |-> is_full)
    else $error("full status reported with room left");

endmodule

// ===== rtl/double_ended_queue.sv =====
// A push, or any command on an empty queue, passes the command queue register and then the
// result register; a pop or list of a non-empty queue reads the ring through a registered
// port before its first result. Throughput: one push or empty-queue command per cycle while
// results are taken; a pop or list holds the back part until its last result is loaded;
// a two-entry command queue decouples input from results.
// Reset empties the ring (head and count cleared); stored identifiers are not cleared.
module double_ended_queue #(
  parameter int DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  deq_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output deq_pkg::out_item_t out_data
);

  logic          cmd_valid;
  deq_pkg::cmd_t cmd;
  logic          cmd_take;

  deq_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take)
  );

  deq_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
